// ===== rtl/segment_deframer_checksum_check_macros.svh =====
// Assertion macros shared by the segment deframer RTL.
// No dependencies; included by the top level only.
`ifndef SEGMENT_DEFRAMER_CHECKSUM_CHECK_MACROS_SVH
`define SEGMENT_DEFRAMER_CHECKSUM_CHECK_MACROS_SVH

// Same-cycle implication, off during reset.
`define SDCC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SDCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdcc_pkg.sv =====
// Shared types and constants for the segment deframer with checksum check.
// No dependencies.
package sdcc_pkg;

  localparam int HEADER_BYTES = 6;
  localparam int SEQ_W        = 16;
  localparam int FLAGS_W      = 3;
  localparam int STATUS_W     = 3;

  localparam logic [15:0] SUM_GOOD      = 16'hFFFF;
  localparam logic [12:0] RESERVED_MASK = 13'h1FFF;
  localparam logic [2:0]  FLAGS_MASK    = 3'h7;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_RESERVED  = 3'd2,
    ST_BAD_SUM   = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // results written into the queue for one accepted byte
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ===== rtl/sdcc_core.sv =====
// Header parse, running one's-complement sum and result formatting.
// Depends on sdcc_pkg.
module sdcc_core import sdcc_pkg::*; #(
  parameter int MAX_PAYLOAD = 1024,
  parameter int IDX_W       = 10,
  parameter int LEN_W       = 11,
  parameter int DATA_W      = 56
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [7:0]        data_byte,
  input  logic              end_of_segment,
  output push_t             push,
  output logic [DATA_W+1:0] entry_a,
  output logic [DATA_W+1:0] entry_b
);

  localparam int LIMIT = HEADER_BYTES + MAX_PAYLOAD + 1;
  localparam int POS_W = $clog2(LIMIT + 1);

  logic [POS_W-1:0] pos, pos_inc, plen, idx;
  logic [15:0]      seq, seq_next, ctrl, ctrl_next;
  logic [15:0]      sum, sum_next, sum_add, word;
  logic [16:0]      sum_wide;
  logic [7:0]       held;
  logic             pending, do_add;
  logic             emit_pay, too_short, too_long;
  logic [LEN_W-1:0] len;
  logic [FLAGS_W-1:0] flags;
  logic [SEQ_W-1:0] rep_seq;
  status_t          status;
  logic [DATA_W-1:0] pay_data, sum_data;

  assign pos_inc = (pos == POS_W'(LIMIT)) ? pos : pos + POS_W'(1);

  assign seq_next  = (pos < POS_W'(2)) ? {seq[7:0], data_byte} : seq;
  assign ctrl_next = (pos >= POS_W'(2) && pos < POS_W'(4)) ? {ctrl[7:0], data_byte} : ctrl;

  // Pair completes a word; an odd final byte closes as the high half.
  assign word     = pending ? {held, data_byte} : {data_byte, 8'h00};
  assign do_add   = pending || end_of_segment;
  assign sum_wide = {1'b0, sum} + {1'b0, word};
  assign sum_add  = sum_wide[15:0] + 16'(sum_wide[16]);
  assign sum_next = do_add ? sum_add : sum;

  assign emit_pay = (pos >= POS_W'(HEADER_BYTES)) &&
                    (pos < POS_W'(HEADER_BYTES + MAX_PAYLOAD));
  assign idx      = pos - POS_W'(HEADER_BYTES);

  assign too_short = pos_inc < POS_W'(HEADER_BYTES);
  assign plen      = pos_inc - POS_W'(HEADER_BYTES);
  assign too_long  = plen > POS_W'(MAX_PAYLOAD);

  always_comb begin
    len     = '0;
    flags   = '0;
    rep_seq = '0;
    status  = ST_TOO_SHORT;
    if (!too_short) begin
      len     = too_long ? LEN_W'(MAX_PAYLOAD) : LEN_W'(plen);
      flags   = ctrl_next[2:0] & FLAGS_MASK;
      rep_seq = seq_next;
      priority if ((ctrl_next[15:3] & RESERVED_MASK) != '0) status = ST_RESERVED;
      else if (sum_next != SUM_GOOD)                        status = ST_BAD_SUM;
      else if (too_long)                                    status = ST_TOO_LONG;
      else                                                  status = ST_OK;
    end
  end

  // tdata: byte, index, sequence, flags, length, status (low to high)
  assign pay_data = DATA_W'({STATUS_W'(0), LEN_W'(0), FLAGS_W'(0), SEQ_W'(0),
                             IDX_W'(idx), data_byte});
  assign sum_data = DATA_W'({status, len, flags, rep_seq, IDX_W'(0), 8'h00});

  assign entry_b = {1'b1, KIND_SUMMARY, sum_data};
  assign entry_a = emit_pay ? {!end_of_segment, KIND_PAYLOAD, pay_data} : entry_b;

  assign push.first  = in_fire && (emit_pay || end_of_segment);
  assign push.second = in_fire && emit_pay && end_of_segment;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      seq     <= '0;
      ctrl    <= '0;
      sum     <= '0;
      held    <= '0;
      pending <= 1'b0;
    end else if (in_fire) begin
      if (end_of_segment) begin
        pos     <= '0;
        seq     <= '0;
        ctrl    <= '0;
        sum     <= '0;
        held    <= '0;
        pending <= 1'b0;
      end else begin
        pos     <= pos_inc;
        seq     <= seq_next;
        ctrl    <= ctrl_next;
        sum     <= sum_next;
        if (!pending) held <= data_byte;
        pending <= !pending;
      end
    end
  end

endmodule

// ===== rtl/sdcc_outq.sv =====
// Four-entry result queue taking up to two results per cycle.
// Depends on sdcc_pkg.
module sdcc_outq import sdcc_pkg::*; #(
  parameter int ENTRY_W = 58
) (
  input  logic               clk,
  input  logic               rst,
  input  push_t              push,
  input  logic [ENTRY_W-1:0] entry_a,
  input  logic [ENTRY_W-1:0] entry_b,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ENTRY_W-1:0] out_entry
);

  logic [ENTRY_W-1:0] mem [Q_DEPTH];
  logic [Q_AW-1:0]    wptr, rptr;
  logic [Q_CW-1:0]    count, count_next;
  logic               pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = count != '0;
  assign out_entry  = mem[rptr];
  // room for a worst-case pair of results
  assign space_ok   = count <= Q_CW'(Q_DEPTH - 2);
  assign count_next = count + Q_CW'(push.first) + Q_CW'(push.second) - Q_CW'(pop);

  always_ff @(posedge clk) begin
    if (push.first)  mem[wptr] <= entry_a;
    if (push.second) mem[wptr + Q_AW'(1)] <= entry_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + Q_AW'(push.first) + Q_AW'(push.second);
      if (pop) rptr <= rptr + Q_AW'(1);
      count <= count_next;
    end
  end

endmodule

// ===== rtl/segment_deframer_checksum_check.sv =====
// Segment deframer with 16-bit one's-complement checksum check, top level.
// Depends on sdcc_pkg, sdcc_core, sdcc_outq and the assertion macro header.
//
// Input stream: one segment byte per transaction in s_tdata, s_tlast on the
// final byte. The first six bytes are the header (sequence number, control
// word, checksum), the rest is payload.
// Output stream: m_tuser = 0 is a payload byte with its index; m_tuser = 1 is
// the segment summary (sequence, flags, length, status) sent after the final
// byte. m_tlast marks the last result caused by one input byte.
// Results for an accepted byte are registered in the result queue and offered
// from there. Throughput: one byte per cycle while s_tready is high; a final
// byte that is itself a payload byte yields two results, which leave one at a time.
// The results sit in a four-entry queue; s_tready stays high while at least
// two entries are free, so a stalled receiver holds the input off once three
// or more results wait. Reset empties the queue and clears the header,
// position and checksum state.
`include "segment_deframer_checksum_check_macros.svh"

module segment_deframer_checksum_check import sdcc_pkg::*; #(
  parameter int MAX_PAYLOAD = 1024,
  localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1),
  localparam int FLD_W  = 8 + IDX_W + SEQ_W + FLAGS_W + LEN_W + STATUS_W,
  localparam int DATA_W = ((FLD_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // data_byte
  input  logic              s_tlast,   // end_of_segment
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // payload_byte, payload_index, sequence_number,
                                       // control_flags, payload_length, status_code
  output logic              m_tuser,   // result_kind
  output logic              m_tlast    // last_result
);

  localparam int ST_OFF = 8 + IDX_W + SEQ_W + FLAGS_W + LEN_W;

  logic              in_fire;
  push_t             push;
  logic [DATA_W+1:0] entry_a, entry_b, out_entry;

  assign in_fire = s_tvalid && s_tready;

  sdcc_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IDX_W       (IDX_W),
    .LEN_W       (LEN_W),
    .DATA_W      (DATA_W)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .in_fire        (in_fire),
    .data_byte      (s_tdata),
    .end_of_segment (s_tlast),
    .push           (push),
    .entry_a        (entry_a),
    .entry_b        (entry_b)
  );

  sdcc_outq #(
    .ENTRY_W (DATA_W + 2)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_a   (entry_a),
    .entry_b   (entry_b),
    .space_ok  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_entry (out_entry)
  );

  assign m_tdata = out_entry[DATA_W-1:0];
  assign m_tuser = out_entry[DATA_W];
  assign m_tlast = out_entry[DATA_W+1];

  `SDCC_ASSERT_IMPLIES(a_summary_last, clk, rst, m_tvalid && m_tuser, m_tlast,
    "summary result without last mark")
  `SDCC_ASSERT_IMPLIES(a_payload_status, clk, rst, m_tvalid && !m_tuser,
    m_tdata[ST_OFF +: STATUS_W] == ST_OK, "payload result carries a status")
  `SDCC_ASSERT_IMPLIES(a_stall_has_data, clk, rst, !s_tready, m_tvalid,
    "input held off with empty result queue")
  `SDCC_ASSERT_NEXT(a_fire_gives_output, clk, rst, in_fire && s_tlast, m_tvalid,
    "no result after the final byte")

endmodule

// ===== tb/segment_deframer_checksum_check_tb.sv =====
// Testbench for segment_deframer_checksum_check: random and directed segments
// against a scoreboard that predicts payload and summary results per byte.
// Depends on sdcc_pkg and the segment_deframer_checksum_check RTL.
`timescale 1ns / 100ps

module segment_deframer_checksum_check_tb;
  import sdcc_pkg::*;

  localparam int MAX_PAYLOAD = 1024;
  localparam int DATA_W      = 56;
  localparam int CYCLE_LIMIT = 400000;

  // m_tdata layout, highest bits first
  typedef struct packed {
    logic [4:0]  pad;
    logic [2:0]  status;
    logic [10:0] len;
    logic [2:0]  flags;
    logic [15:0] seq;
    logic [9:0]  idx;
    logic [7:0]  pbyte;
  } result_fields_t;

  typedef struct {
    kind_t          kind;
    result_fields_t f;
    logic           last;
  } deframe_result_t;

  class deframe_scoreboard;
    logic [10:0]     byte_pos;
    logic [15:0]     seq_word;
    logic [15:0]     ctrl_word;
    logic [15:0]     running_sum;
    logic [7:0]      high_half;
    bit              half_waiting;
    deframe_result_t awaited[$];
    int              errors;

    function new();
      errors = 0;
      clear_segment();
    endfunction

    function void clear_segment();
      byte_pos     = '0;
      seq_word     = '0;
      ctrl_word    = '0;
      running_sum  = '0;
      high_half    = '0;
      half_waiting = 1'b0;
    endfunction

    // one's-complement add with end-around carry
    static function logic [15:0] fold_add(logic [15:0] acc, logic [15:0] word);
      logic [16:0] s;
      s = acc + word;
      return s[15:0] + 16'(s[16]);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      logic [10:0]     pos;
      int unsigned     plen;
      deframe_result_t r;
      pos = byte_pos;
      if (pos < 2) seq_word = {seq_word[7:0], b};
      else if (pos < 4) ctrl_word = {ctrl_word[7:0], b};

      if (!half_waiting) begin
        high_half    = b;
        half_waiting = 1'b1;
      end else begin
        running_sum  = fold_add(running_sum, {high_half, b});
        half_waiting = 1'b0;
      end

      if (pos >= HEADER_BYTES && pos - HEADER_BYTES < MAX_PAYLOAD) begin
        r.kind    = KIND_PAYLOAD;
        r.f       = '0;
        r.f.pbyte = b;
        r.f.idx   = 10'(pos - HEADER_BYTES);
        r.last    = !eos;
        awaited.push_back(r);
      end

      // position saturates one past the largest legal segment
      if (pos < HEADER_BYTES + MAX_PAYLOAD + 1) pos = pos + 1'b1;
      byte_pos = pos;

      if (eos) begin
        if (half_waiting) running_sum = fold_add(running_sum, {high_half, 8'h00});
        r.kind = KIND_SUMMARY;
        r.f    = '0;
        r.last = 1'b1;
        if (pos < HEADER_BYTES) begin
          r.f.status = ST_TOO_SHORT;
        end else begin
          plen     = pos - HEADER_BYTES;
          r.f.seq   = seq_word;
          r.f.flags = ctrl_word[2:0];
          r.f.len   = 11'((plen > MAX_PAYLOAD) ? MAX_PAYLOAD : plen);
          if (ctrl_word[15:3] != '0) r.f.status = ST_RESERVED;
          else if (running_sum != SUM_GOOD) r.f.status = ST_BAD_SUM;
          else if (plen > MAX_PAYLOAD) r.f.status = ST_TOO_LONG;
          else r.f.status = ST_OK;
        end
        awaited.push_back(r);
        clear_segment();
      end
    endfunction

    function void compare(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] data, logic user, logic last);
      deframe_result_t want;
      result_fields_t  got;
      got = data;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0b data %0h last %0b",
                 $time, user, data, last);
        return;
      end
      want = awaited.pop_front();
      compare("result_kind", 16'(want.kind), 16'(user));
      compare("payload_byte", 16'(want.f.pbyte), 16'(got.pbyte));
      compare("payload_index", 16'(want.f.idx), 16'(got.idx));
      compare("sequence_number", want.f.seq, got.seq);
      compare("control_flags", 16'(want.f.flags), 16'(got.flags));
      compare("payload_length", 16'(want.f.len), 16'(got.len));
      compare("status_code", 16'(want.f.status), 16'(got.status));
      compare("tdata padding", 16'(want.f.pad), 16'(got.pad));
      compare("last_result", 16'(want.last), 16'(last));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;   // data_byte
  logic              s_tlast = 1'b0; // end_of_segment
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;        // payload_byte, payload_index, sequence_number,
                                     // control_flags, payload_length, status_code
  logic              m_tuser;        // result_kind
  logic              m_tlast;        // last_result

  deframe_scoreboard sb;
  int                items_sent = 0;
  int                cycles = 0;
  bit                tx_steady = 1'b0;
  bit                rx_steady = 1'b0;

  segment_deframer_checksum_check #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // handshake values are stable at the falling edge and hold to the next rising one
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  initial begin : receiver
    int stall;
    bit took;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(negedge clk);
        took = m_tvalid;
        @(posedge clk);
      end while (!took);
    end
  end

  // returns at the rising edge where the byte was taken, with tvalid still high
  task automatic send_byte(logic [7:0] b, logic eos);
    int gap;
    bit ok;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    sb.note_byte(b, eos);
    items_sent++;
  endtask

  task automatic send_bytes(logic [7:0] seg[$]);
    if ($urandom_range(0, 5) == 0) tx_steady = !tx_steady;
    foreach (seg[i]) send_byte(seg[i], i == seg.size() - 1);
  endtask

  // random bytes with no regard for header layout
  task automatic send_raw(int len);
    logic [7:0] seg[$];
    repeat (len) seg.push_back(8'($urandom_range(0, 255)));
    send_bytes(seg);
  endtask

  task automatic send_segment(logic [15:0] seq, logic [15:0] ctrl, int plen, bit corrupt);
    logic [7:0]  seg[$];
    logic [15:0] sum;
    logic [15:0] cksum;
    seg = '{seq[15:8], seq[7:0], ctrl[15:8], ctrl[7:0], 8'h00, 8'h00};
    repeat (plen) seg.push_back(8'($urandom_range(0, 255)));
    sum = '0;
    for (int i = 0; i < seg.size(); i += 2)
      sum = deframe_scoreboard::fold_add(sum, {seg[i], (i + 1 < seg.size()) ? seg[i+1] : 8'h00});
    cksum = ~sum;
    if (corrupt) cksum ^= 16'($urandom_range(1, 65535));
    seg[4] = cksum[15:8];
    seg[5] = cksum[7:0];
    send_bytes(seg);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin : stimulus
    bit          paused;
    int          pick;
    int          plen;
    logic [15:0] ctrl;
    paused = 1'b0;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short segments, header only, reserved bits set, bad checksum
    send_raw(1);
    send_raw(4);
    send_segment(16'hFFFF, 16'h0007, 0, 1'b0);
    send_segment(16'h0000, 16'h8000, 1, 1'b1);
    send_segment(16'h0000, 16'h0000, 0, 1'b1);
    drain_results();

    while (items_sent < 700) begin
      if (!paused && items_sent > 400) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_raw($urandom_range(1, 12));
      end else if (pick == 1) begin
        send_raw($urandom_range(1, HEADER_BYTES - 1));
      end else begin
        if ($urandom_range(0, 4) == 0)
          ctrl = {13'($urandom_range(1, 8191)), 3'($urandom_range(0, 7))};
        else
          ctrl = {13'h0000, 3'($urandom_range(0, 7))};
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        send_segment(16'($urandom_range(0, 65535)), ctrl, plen, $urandom_range(0, 5) == 0);
      end
    end

    // payload at the limit, just past it, and well past it with a bad checksum
    send_segment(16'($urandom_range(0, 65535)), 16'h0005, MAX_PAYLOAD, 1'b0);
    send_segment(16'($urandom_range(0, 65535)), 16'h0002, MAX_PAYLOAD + 1, 1'b0);
    send_segment(16'($urandom_range(0, 65535)), 16'h0000, MAX_PAYLOAD + 6, 1'b1);

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sdcc_pkg.sv
rtl/sdcc_core.sv
rtl/sdcc_outq.sv
rtl/segment_deframer_checksum_check.sv
tb/segment_deframer_checksum_check_tb.sv
